### hw/rtl/nat_pba_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the NAT port-block allocator. No dependencies.
package nat_pba_pkg;

    localparam int NUM_ADDRESSES  = 16;
    localparam int NUM_BLOCKS     = 64;
    localparam int MAX_BLOCK_LOG2 = 6;
    localparam int MIN_BLOCK_LOG2 = 3;

    localparam int ADDR_W = $clog2(NUM_ADDRESSES);
    localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int MEM_AW = ADDR_W + BLK_W;
    localparam int MEM_DEPTH = NUM_ADDRESSES * NUM_BLOCKS;
    localparam int MAP_W  = 1 << MAX_BLOCK_LOG2;
    localparam int BIT_W  = MAX_BLOCK_LOG2;
    localparam int NUM_PROTO = 3;

    // register indexes
    localparam logic [1:0] REG_PORT_BASE  = 2'd0;
    localparam logic [1:0] REG_BLOCK_LOG2 = 2'd1;
    localparam logic [1:0] REG_BLOCK_CNT  = 2'd2;

    // IP protocol numbers
    localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;
    localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
    localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;

    // bitmap selects
    localparam logic [1:0] SEL_TCP  = 2'd0;
    localparam logic [1:0] SEL_UDP  = 2'd1;
    localparam logic [1:0] SEL_ICMP = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FAIL   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic clr;       // clearing pass step
        logic load;      // capture request word
        logic rd;        // read owner and bitmaps of current block
        logic next;      // advance block counter
        logic ev_rec;    // note first unowned block
        logic hit_wr;    // take bit in owned block
        logic claim_wr;  // claim first unowned block
        logic res_reject;
        logic res_fail;
        logic out_load;  // move result into output register
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic reject;
        logic empty;
        logic hit;
        logic last;
        logic have_free;
        logic out_busy;
    } sts_t;

endpackage

### hw/rtl/nat_port_block_allocator.sv
// Top level of the NAT port-block allocator.
// Joins nat_pba_ctrl and nat_pba_dp; uses nat_pba_pkg.

// After reset the block runs a clearing pass over the owner and bitmap
// memories, one entry per cycle, NUM_ADDRESSES*NUM_BLOCKS = 1024 entries,
// with in_stall high; configuration writes are taken during that time.
// A request is then captured and checked, and each scanned block gets
// one memory read and one evaluation; a claim step follows if needed,
// and the result word is then handed to the output register once that
// register is free or not stalled. One request is worked at a time; the
// next one is accepted while the previous result waits.
module nat_port_block_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] subscriber,
    input  logic [3:0]  address_index,
    input  logic [7:0]  proto,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] port,
    output logic        block_claimed
);
    import nat_pba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    nat_pba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    nat_pba_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_stall     (out_stall),
        .subscriber    (subscriber),
        .address_index (address_index),
        .proto         (proto),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .status        (status),
        .port          (port),
        .block_claimed (block_claimed)
    );

`ifndef SYNTHESIS
    // a failed or rejected word never carries a port
    a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> port == 16'd0)
        else $error("port set on unsuccessful result");
    // a rejected request never claims a block
    a_reject_no_claim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_claimed |-> status != ST_REJECT)
        else $error("block claimed on rejected request");
    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");
`endif

endmodule

### hw/rtl/nat_pba_ctrl.sv
// Sequencer for the NAT port-block allocator: clearing pass, block scan,
// claim and result hand-off. Depends on nat_pba_pkg.
module nat_pba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              out_stall,
    input  nat_pba_pkg::sts_t sts,
    output nat_pba_pkg::cmd_t cmd
);
    import nat_pba_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_EV    = 3'd4;
    localparam logic [2:0] S_CLAIM = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (sts.reject)
                begin
                    cmd.res_reject = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.empty)
                begin
                    cmd.res_fail = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd = 1'b1;
                state_next = S_EV;
            end
            S_EV:
            begin
                cmd.ev_rec = 1'b1;
                priority if (sts.hit)
                begin
                    cmd.hit_wr = 1'b1;
                    state_next = S_DONE;
                end
                else if (!sts.last)
                begin
                    cmd.next = 1'b1;
                    state_next = S_RD;
                end
                else if (sts.have_free)
                begin
                    state_next = S_CLAIM;
                end
                else
                begin
                    cmd.res_fail = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_CLAIM:
            begin
                cmd.claim_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

`ifndef SYNTHESIS
    // the scan only writes after the block's read data came back
    a_hit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit_wr |-> $past(cmd.rd))
        else $error("bitmap write without preceding read");
    // a claim always follows the last scanned block
    a_claim_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLAIM) |-> $past(state_reg == S_EV && sts.last))
        else $error("claim without finished scan");
    // no request is taken during the clearing pass
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> in_stall)
        else $error("input taken during clearing pass");
`endif

endmodule

### hw/rtl/nat_pba_dp.sv
// Datapath of the NAT port-block allocator: configuration, request word,
// owner and bitmap memories, bit search and output register. Uses nat_pba_pkg.
module nat_pba_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              out_stall,
    input  logic [31:0]       subscriber,
    input  logic [3:0]        address_index,
    input  logic [7:0]        proto,
    input  nat_pba_pkg::cmd_t cmd,
    output nat_pba_pkg::sts_t sts,
    output logic              out_valid,
    output logic [1:0]        status,
    output logic [15:0]       port,
    output logic              block_claimed
);
    import nat_pba_pkg::*;

    // configuration
    logic [15:0] port_base_reg;
    logic [2:0]  block_log2_reg;
    logic [6:0]  block_cnt_reg;

    // request
    logic [31:0]       sub_reg;
    logic [3:0]        addr_reg;
    logic [1:0]        sel_reg;
    logic              reject_reg;
    logic [2:0]        lg_reg;
    logic [CNT_W-1:0]  nblk_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              free_found_reg;
    logic [BLK_W-1:0]  free_blk_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;

    // memories
    logic [31:0]              owner_mem [MEM_DEPTH];
    logic [NUM_PROTO*MAP_W-1:0] map_mem [MEM_DEPTH];
    logic [31:0]              owner_q;
    logic [NUM_PROTO*MAP_W-1:0] map_q;

    // result and output
    logic [1:0]  res_status_reg;
    logic [15:0] res_port_reg;
    logic        res_claim_reg;
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] port_reg;
    logic        claimed_reg;

    logic [MAP_W-1:0]   word, mask, free_bits, low_bit;
    logic [BIT_W-1:0]   bit_idx;
    logic [BLK_W-1:0]   cur_blk;
    logic [MEM_AW-1:0]  rd_addr, wr_addr;
    logic               we;
    logic [31:0]        wr_owner;
    logic [NUM_PROTO*MAP_W-1:0] wr_map, sel_bit;
    logic [1:0]         sel_in;
    logic               sel_ok;
    logic [2:0]         lg_in;
    logic [6:0]         nblk_in;
    logic [15:0]        port_hit, port_claim;

    // one-hot to index
    function automatic logic [BIT_W-1:0] onehot_idx(input logic [MAP_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int k = 0; k < MAP_W; k++)
        begin
            if (v[k])
            begin
                r = r | BIT_W'(k);
            end
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_base_reg  <= 16'd1024;
            block_log2_reg <= 3'd6;
            block_cnt_reg  <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PORT_BASE:  port_base_reg  <= cfg_data;
                REG_BLOCK_LOG2: block_log2_reg <= cfg_data[2:0];
                REG_BLOCK_CNT:  block_cnt_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // protocol decode and config clamping
    always_comb
    begin
        sel_ok = 1'b1;
        sel_in = SEL_TCP;
        unique case (proto)
            PROTO_NUM_TCP:  sel_in = SEL_TCP;
            PROTO_NUM_UDP:  sel_in = SEL_UDP;
            PROTO_NUM_ICMP: sel_in = SEL_ICMP;
            default:        sel_ok = 1'b0;
        endcase
        lg_in = block_log2_reg;
        if (32'(block_log2_reg) < MIN_BLOCK_LOG2)
        begin
            lg_in = 3'(MIN_BLOCK_LOG2);
        end
        if (32'(block_log2_reg) > MAX_BLOCK_LOG2)
        begin
            lg_in = 3'(MAX_BLOCK_LOG2);
        end
        nblk_in = block_cnt_reg;
        if (32'(block_cnt_reg) > NUM_BLOCKS)
        begin
            nblk_in = 7'(NUM_BLOCKS);
        end
    end

    // request and scan state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sub_reg    <= subscriber;
            addr_reg   <= address_index;
            sel_reg    <= sel_in;
            reject_reg <= !sel_ok || (subscriber == 32'd0) ||
                          (32'(address_index) >= NUM_ADDRESSES);
            lg_reg     <= lg_in;
            nblk_reg   <= CNT_W'(nblk_in);
            cnt_reg    <= '0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.next)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.ev_rec && !free_found_reg && owner_q == 32'd0)
            begin
                free_found_reg <= 1'b1;
                free_blk_reg   <= cur_blk;
            end
        end
    end

    // clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign cur_blk = cnt_reg[BLK_W-1:0];
    assign rd_addr = {addr_reg[ADDR_W-1:0], cur_blk};

    // memories: registered read, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            owner_q <= owner_mem[rd_addr];
            map_q   <= map_mem[rd_addr];
        end
        if (we)
        begin
            owner_mem[wr_addr] <= wr_owner;
            map_mem[wr_addr]   <= wr_map;
        end
    end

    // lowest free bit of the selected bitmap
    always_comb
    begin
        word = map_q[sel_reg*MAP_W +: MAP_W];
        mask = (lg_reg >= 3'(MAX_BLOCK_LOG2)) ? '1 :
               ((MAP_W'(1) << lg_reg) - MAP_W'(1));
        free_bits = ~word & mask;
        low_bit   = free_bits & (~free_bits + MAP_W'(1));
        bit_idx   = onehot_idx(low_bit);
        port_hit  = port_base_reg + (16'(cur_blk) << lg_reg) + 16'(bit_idx);
        port_claim = port_base_reg + (16'(free_blk_reg) << lg_reg);
    end

    // write port mux
    always_comb
    begin
        we       = cmd.clr || cmd.hit_wr || cmd.claim_wr;
        wr_addr  = rd_addr;
        wr_owner = sub_reg;
        sel_bit  = '0;
        sel_bit[sel_reg*MAP_W +: MAP_W] = low_bit;
        wr_map   = map_q | sel_bit;
        priority if (cmd.clr)
        begin
            wr_addr  = clr_cnt_reg;
            wr_owner = '0;
            wr_map   = '0;
        end
        else if (cmd.claim_wr)
        begin
            // an unowned block has never had a bit set since reset
            wr_addr = {addr_reg[ADDR_W-1:0], free_blk_reg};
            wr_map  = '0;
            wr_map[sel_reg*MAP_W] = 1'b1;
        end
        else
        begin
        end
    end

    // status to controller
    always_comb
    begin
        sts.clr_last  = (32'(clr_cnt_reg) == MEM_DEPTH - 1);
        sts.reject    = reject_reg;
        sts.empty     = (nblk_reg == '0);
        sts.hit       = (owner_q == sub_reg) && (free_bits != '0);
        sts.last      = (cnt_reg + 1'b1 >= nblk_reg);
        sts.have_free = free_found_reg || (owner_q == 32'd0);
        sts.out_busy  = out_valid_reg;
    end

    // result register
    always_ff @(posedge clk)
    begin
        priority if (cmd.hit_wr)
        begin
            res_status_reg <= ST_OK;
            res_port_reg   <= port_hit;
            res_claim_reg  <= 1'b0;
        end
        else if (cmd.claim_wr)
        begin
            res_status_reg <= ST_OK;
            res_port_reg   <= port_claim;
            res_claim_reg  <= 1'b1;
        end
        else if (cmd.res_reject)
        begin
            res_status_reg <= ST_REJECT;
            res_port_reg   <= '0;
            res_claim_reg  <= 1'b0;
        end
        else if (cmd.res_fail)
        begin
            res_status_reg <= ST_FAIL;
            res_port_reg   <= '0;
            res_claim_reg  <= 1'b0;
        end
        else
        begin
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg  <= res_status_reg;
            port_reg    <= res_port_reg;
            claimed_reg <= res_claim_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign port          = port_reg;
    assign block_claimed = claimed_reg;

endmodule
